>>> rtl/core/bpc_pkg.sv
// Package with shared types and constants of the pressure compensation unit.
`default_nettype none
package bpc_pkg;
  localparam logic [1:0] REG_CAL_A = 2'd0;
  localparam logic [1:0] REG_CAL_B = 2'd1;
  localparam logic [1:0] REG_CAL_C = 2'd2;
  localparam logic [1:0] REG_OSS   = 2'd3;
  localparam logic CMD_TEMP  = 1'b0;
  localparam logic CMD_PRESS = 1'b1;

  typedef struct packed {
    logic        start;
    logic        signed_mode;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;
endpackage
`default_nettype wire

>>> rtl/core/bpc_mul.sv
// Bit-serial 32 by 32 multiplier giving the low 32 bits of the product.
`default_nettype none
module bpc_mul (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic             done,
  output logic [31:0]      product
);
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] mcand_r, mcand_nxt;
  logic [31:0] mplier_r, mplier_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;

  always_comb begin
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    cnt_nxt    = cnt_r;
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    if (start) begin
      acc_nxt    = '0;
      mcand_nxt  = a;
      mplier_nxt = b;
      cnt_nxt    = '0;
      busy_nxt   = 1'b1;
    end else if (busy_r) begin
      if (mplier_r[0]) acc_nxt = acc_r + mcand_r;
      mcand_nxt  = {mcand_r[30:0], 1'b0};
      mplier_nxt = {1'b0, mplier_r[31:1]};
      cnt_nxt    = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

  assign done    = done_r;
  assign product = acc_r;
endmodule
`default_nettype wire

>>> rtl/core/bpc_div.sv
// Radix-2 restoring divider, unsigned or signed truncating toward zero.
`default_nettype none
module bpc_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bpc_pkg::div_req_t req,
  output bpc_pkg::div_rsp_t      rsp
);
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic        neg_r, neg_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;
  logic [32:0] shifted;
  logic [31:0] mag_a, mag_b;

  always_comb begin
    mag_a = (req.signed_mode && req.dividend[31]) ? (32'd0 - req.dividend) : req.dividend;
    mag_b = (req.signed_mode && req.divisor[31]) ? (32'd0 - req.divisor) : req.divisor;
    shifted = {rem_r, quo_r[31]};
    trial   = shifted - {1'b0, dvs_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = mag_a;
      dvs_nxt  = mag_b;
      neg_nxt  = req.signed_mode && (req.dividend[31] ^ req.divisor[31]);
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = shifted[31:0];
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        if (neg_r) quo_nxt = 32'd0 - quo_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;
endmodule
`default_nettype wire

>>> rtl/core/barometric_pressure_compensation_unit.sv
// Top level of the barometric pressure compensation unit.
// Input requests carry cmd (0 temperature, 1 pressure) and a raw reading.
// Each request yields one result with kind, value and a divide error flag.
// Calibration words and the oversampling setting are written on the cfg
// channel, register index 0 to 3; other indexes are ignored.
// All arithmetic runs through one bit-serial multiplier and one radix-2
// divider, sequenced by a step counter.  Each unit reports its result in the
// cycle after its last step.  A temperature request takes one product and one
// quotient; a pressure request takes ten products and one quotient.  A zero
// divisor ends the request early.  One request is worked on at a time, and
// the next one is taken in the cycle the result appears.  The result waits
// in an output register; while the receiver stalls, the next request is
// already accepted and computed, then held until the output register frees.
// Reset clears the calibration to zero, the oversampling setting to three and
// the stored temperature factor to zero.
`default_nettype none
module barometric_pressure_compensation_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // raw_value[23:0]
  input  wire logic        in_tuser,   // cmd
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // value[31:0]
  output logic [1:0]       out_tuser,  // divide_error, kind
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_OP   = 5'b00010,
    ST_WAIT = 5'b00100,
    ST_DONE = 5'b01000,
    ST_HOLD = 5'b10000
  } state_t;

  state_t      state_r, state_nxt;
  logic [63:0] cal_a_r, cal_b_r;
  logic [31:0] cal_c_r;
  logic [1:0]  oss_r;
  logic [31:0] tf_r, tf_nxt;
  logic        cmd_r, cmd_nxt;
  logic [23:0] raw_r, raw_nxt;
  logic [4:0]  step_r, step_nxt;
  logic [31:0] t0_r, t0_nxt, t1_r, t1_nxt, t2_r, t2_nxt, t3_r, t3_nxt;
  logic [31:0] res_r, res_nxt;
  logic        err_r, err_nxt;
  logic        ov_r, ov_nxt;
  logic [31:0] ob_val_r;
  logic        ob_kind_r, ob_err_r;

  logic        mul_start, mul_done;
  logic [31:0] mul_a, mul_b, mul_p;
  bpc_pkg::div_req_t div_req;
  bpc_pkg::div_rsp_t div_rsp;
  logic        use_div;
  logic        op_last;

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  logic [31:0] ut, up;

  bpc_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .product(mul_p)
  );
  bpc_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] s);
    asr = 32'($signed(x) >>> s);
  endfunction

  always_comb begin
    ac1 = {{16{cal_a_r[63]}}, cal_a_r[63:48]};
    ac2 = {{16{cal_a_r[47]}}, cal_a_r[47:32]};
    ac3 = {{16{cal_a_r[31]}}, cal_a_r[31:16]};
    ac4 = {16'd0, cal_a_r[15:0]};
    ac5 = {16'd0, cal_b_r[63:48]};
    ac6 = {16'd0, cal_b_r[47:32]};
    b1  = {{16{cal_b_r[31]}}, cal_b_r[31:16]};
    b2  = {{16{cal_b_r[15]}}, cal_b_r[15:0]};
    mc  = {{16{cal_c_r[31]}}, cal_c_r[31:16]};
    md  = {{16{cal_c_r[15]}}, cal_c_r[15:0]};
    ut  = {16'd0, raw_r[15:0]};
    up  = {8'd0, raw_r} >> (4'd8 - {2'd0, oss_r});
  end

  // Operation program: per step select operands of the multiplier or divider.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    use_div = 1'b0;
    op_last = 1'b0;
    div_req.signed_mode = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    if (cmd_r == bpc_pkg::CMD_TEMP) begin
      case (step_r)
        5'd0: begin mul_a = ut - ac6; mul_b = ac5; end
        default: begin
          use_div = 1'b1;
          op_last = 1'b1;
          div_req.signed_mode = 1'b1;
          div_req.dividend = {mc[20:0], 11'd0};
          div_req.divisor  = t0_r + md;
        end
      endcase
    end else begin
      case (step_r)
        5'd0: begin mul_a = t0_r; mul_b = t0_r; end
        5'd1: begin mul_a = t1_r; mul_b = b2; end
        5'd2: begin mul_a = ac2; mul_b = t0_r; end
        5'd3: begin mul_a = ac3; mul_b = t0_r; end
        5'd4: begin mul_a = b1; mul_b = t1_r; end
        5'd5: begin mul_a = ac4; mul_b = t3_r; end
        5'd6: begin mul_a = up - t2_r; mul_b = 32'd50000 >> oss_r; end
        5'd7: begin
          use_div = 1'b1;
          div_req.dividend = t1_r[31] ? t1_r : {t1_r[30:0], 1'b0};
          div_req.divisor  = t3_r;
        end
        5'd8: begin mul_a = asr(res_r, 5'd8); mul_b = asr(res_r, 5'd8); end
        5'd9: begin mul_a = t1_r; mul_b = 32'd3038; end
        default: begin mul_a = res_r; mul_b = 32'd0 - 32'd7357; op_last = 1'b1; end
      endcase
    end
    div_req.start = (state_r == ST_OP) && use_div && !(div_req.divisor == 32'd0);
  end

  assign mul_start     = (state_r == ST_OP) && !use_div;

  always_comb begin
    logic [31:0] x;
    logic [31:0] q;
    x = '0;
    q = '0;
    state_nxt = state_r;
    tf_nxt = tf_r;
    cmd_nxt = cmd_r;
    raw_nxt = raw_r;
    step_nxt = step_r;
    t0_nxt = t0_r; t1_nxt = t1_r; t2_nxt = t2_r; t3_nxt = t3_r;
    res_nxt = res_r;
    err_nxt = err_r;
    ov_nxt = ov_r;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt = in_tuser;
          raw_nxt = in_tdata;
          step_nxt = '0;
          err_nxt = 1'b0;
          t0_nxt = tf_r - 32'd4000;
          state_nxt = ST_OP;
        end
      end
      ST_OP: begin
        if (use_div && div_req.divisor == 32'd0) begin
          if (cmd_r == bpc_pkg::CMD_TEMP) tf_nxt = t0_r;
          res_nxt = '0;
          err_nxt = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (mul_done || div_rsp.done) begin
          q = div_rsp.quotient;
          x = mul_p;
          if (cmd_r == bpc_pkg::CMD_TEMP) begin
            if (step_r == 5'd0) t0_nxt = asr(x, 5'd15);
            else begin
              tf_nxt = t0_r + q;
              res_nxt = asr(t0_r + q + 32'd8, 5'd4);
            end
          end else begin
            case (step_r)
              5'd0: t1_nxt = asr(x, 5'd12);
              5'd1: t2_nxt = asr(x, 5'd11);
              5'd2: t2_nxt = (asr(((ac1 << 2) + t2_r + asr(x, 5'd11)) << oss_r
                              + 32'd0, 5'd0) + 32'd2);
              5'd3: t3_nxt = asr(x, 5'd13);
              5'd4: t3_nxt = asr(t3_r + asr(x, 5'd16) + 32'd2, 5'd2) + 32'd32768;
              5'd5: t3_nxt = x >> 15;
              5'd6: t1_nxt = x;
              5'd7: res_nxt = t1_r[31] ? {q[30:0], 1'b0} : q;
              5'd8: t1_nxt = x;
              5'd9: t1_nxt = asr(x, 5'd16);
              default: res_nxt = res_r + asr(t1_r + asr(x, 5'd16) + 32'd3791, 5'd4);
            endcase
            if (step_r == 5'd2) t2_nxt = asr(t2_nxt, 5'd2);
          end
          step_nxt = step_r + 5'd1;
          state_nxt = op_last ? ST_DONE : ST_OP;
        end
      end
      ST_DONE: begin
        if (!ov_nxt) begin
          ov_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!ov_nxt) begin
          ov_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cal_a_r <= '0;
      cal_b_r <= '0;
      cal_c_r <= '0;
      oss_r   <= 2'd3;
      tf_r    <= '0;
      ov_r    <= 1'b0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      tf_r    <= tf_nxt;
      ov_r    <= ov_nxt;
      step_r  <= step_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          bpc_pkg::REG_CAL_A: cal_a_r <= cfg_data;
          bpc_pkg::REG_CAL_B: cal_b_r <= cfg_data;
          bpc_pkg::REG_CAL_C: cal_c_r <= cfg_data[31:0];
          bpc_pkg::REG_OSS:   oss_r   <= cfg_data[1:0];
          default: ;
        endcase
      end
    end
    cmd_r <= cmd_nxt;
    raw_r <= raw_nxt;
    t0_r <= t0_nxt; t1_r <= t1_nxt; t2_r <= t2_nxt; t3_r <= t3_nxt;
    res_r <= res_nxt;
    err_r <= err_nxt;
    if ((state_r == ST_DONE || state_r == ST_HOLD) && state_nxt == ST_IDLE) begin
      ob_val_r  <= res_r;
      ob_kind_r <= cmd_r;
      ob_err_r  <= err_r;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = ov_r;
  assign out_tdata  = ob_val_r;
  assign out_tuser  = {ob_err_r, ob_kind_r};
endmodule
`default_nettype wire

>>> rtl/core/bpc_checker.sv
// Port-level checker for the pressure compensation unit, with its bind.
`default_nettype none
module bpc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic [1:0]  out_tuser
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata == 32'd0)
    else $error("divide error with nonzero value");
  a_no_back: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted back to back");
endmodule

bind barometric_pressure_compensation_unit bpc_checker u_bpc_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);
`default_nettype wire

>>> dv/testbench.sv
// Testbench of the barometric pressure compensation unit: stream, predict and compare.
`timescale 1ns / 100ps
module testbench;

  localparam int CYCLE_LIMIT = 5000000;
  localparam int DRAIN_CYCLES = 500;

  typedef struct packed {
    logic        kind;
    logic [31:0] value;
    logic        divide_error;
  } reading_t;

  class pressure_scoreboard;
    logic [63:0] cal_a;
    logic [63:0] cal_b;
    logic [31:0] cal_c;
    logic [1:0]  oss;
    logic [31:0] temp_factor;
    reading_t    expected_q[$];
    int          errors;

    function new();
      cal_a = '0;
      cal_b = '0;
      cal_c = '0;
      oss = 2'd3;
      temp_factor = '0;
      errors = 0;
    endfunction

    function automatic logic [31:0] sra(logic [31:0] x, int s);
      return $signed(x) >>> s;
    endfunction

    function automatic logic [31:0] sext(logic [15:0] v);
      return {{16{v[15]}}, v};
    endfunction

    function void write_reg(logic [1:0] index, logic [63:0] data);
      case (index)
        bpc_pkg::REG_CAL_A: cal_a = data;
        bpc_pkg::REG_CAL_B: cal_b = data;
        bpc_pkg::REG_CAL_C: cal_c = data[31:0];
        bpc_pkg::REG_OSS:   oss = data[1:0];
        default: ;
      endcase
    endfunction

    function automatic reading_t compensate(logic cmd, logic [23:0] raw);
      reading_t r;
      logic [31:0] ut, ac5, ac6, mc, md, prod, x1, x2, x3, den;
      logic [31:0] ac1, ac2, ac3, ac4, b1, b2, up, b6, sq, b3, b4, b7, p;
      r.kind = cmd;
      r.value = '0;
      r.divide_error = 1'b0;
      if (cmd == bpc_pkg::CMD_TEMP) begin
        ut = {16'b0, raw[15:0]};
        ac5 = {16'b0, cal_b[63:48]};
        ac6 = {16'b0, cal_b[47:32]};
        mc = sext(cal_c[31:16]);
        md = sext(cal_c[15:0]);
        prod = (ut - ac6) * ac5;
        x1 = sra(prod, 15);
        den = x1 + md;
        if (den == 0) begin
          temp_factor = x1;
          r.divide_error = 1'b1;
        end else begin
          x3 = mc << 11;
          x2 = $signed(x3) / $signed(den);
          temp_factor = x1 + x2;
          r.value = sra(temp_factor + 32'd8, 4);
        end
      end else begin
        ac1 = sext(cal_a[63:48]);
        ac2 = sext(cal_a[47:32]);
        ac3 = sext(cal_a[31:16]);
        ac4 = {16'b0, cal_a[15:0]};
        b1 = sext(cal_b[31:16]);
        b2 = sext(cal_b[15:0]);
        up = {8'b0, raw} >> (8 - oss);
        b6 = temp_factor - 32'd4000;
        prod = b6 * b6;
        sq = sra(prod, 12);
        prod = sq * b2;
        x1 = sra(prod, 11);
        prod = ac2 * b6;
        x2 = sra(prod, 11);
        x3 = x1 + x2;
        prod = ((ac1 * 32'd4 + x3) << oss) + 32'd2;
        b3 = sra(prod, 2);
        prod = ac3 * b6;
        x1 = sra(prod, 13);
        prod = b1 * sq;
        x2 = sra(prod, 16);
        x3 = sra(x1 + x2 + 32'd2, 2);
        prod = ac4 * (x3 + 32'd32768);
        b4 = prod >> 15;
        b7 = (up - b3) * (32'd50000 >> oss);
        if (b4 == 0) begin
          r.divide_error = 1'b1;
        end else begin
          if (b7 < 32'h80000000) p = (b7 << 1) / b4;
          else p = (b7 / b4) << 1;
          x1 = sra(p, 8);
          x1 = x1 * x1;
          prod = x1 * 32'd3038;
          x1 = sra(prod, 16);
          prod = p * (32'd0 - 32'd7357);
          x2 = sra(prod, 16);
          p = p + sra(x1 + x2 + 32'd3791, 4);
          r.value = p;
        end
      end
      return r;
    endfunction

    function void note_request(logic cmd, logic [23:0] raw);
      expected_q.push_back(compensate(cmd, raw));
    endfunction

    function void check_result(logic kind, logic [31:0] value, logic divide_error);
      reading_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result kind=%0d value=%0d", kind, $signed(value));
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (kind !== e.kind) begin
        $error("kind: expected %0d, actual %0d", e.kind, kind);
        errors++;
      end
      if (value !== e.value) begin
        $error("value: expected %0d, actual %0d", $signed(e.value), $signed(value));
        errors++;
      end
      if (divide_error !== e.divide_error) begin
        $error("divide_error: expected %0d, actual %0d", e.divide_error, divide_error);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  pressure_scoreboard sb = new();
  bit   quiet = 1'b0;
  bit   hold_req = 1'b0;
  int   cycles = 0;

  barometric_pressure_compensation_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tuser[0], out_tdata, out_tuser[1]);
  end

  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (3000) @(negedge clk);
        hold_req = 1'b0;
      end else if (stall > 0 && !quiet) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 15);
      end
    end
  end

  task automatic send_reading(logic cmd, logic [23:0] raw);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= raw;
    do @(posedge clk); while (!in_tready);
    sb.note_request(cmd, raw);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15) - 1) @(negedge clk);
    end
  endtask

  task automatic write_reg(logic [1:0] index, logic [63:0] data);
    @(negedge clk);
    in_tvalid <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(index, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [63:0] typical_cal_a(bit jitter);
    logic [15:0] j;
    j = jitter ? 16'($urandom_range(0, 63)) : 16'd0;
    return {16'd408 + j, -16'sd72, -16'sd14383, 16'd32741 - j};
  endfunction

  function automatic logic [63:0] typical_cal_b(bit jitter);
    logic [15:0] j;
    j = jitter ? 16'($urandom_range(0, 63)) : 16'd0;
    return {16'd32757 - j, 16'd23153 + j, 16'd6190, 16'd4};
  endfunction

  function automatic logic [31:0] typical_cal_c(bit jitter);
    logic [15:0] j;
    j = jitter ? 16'($urandom_range(0, 63)) : 16'd0;
    return {-16'sd8711, 16'd2868 + j};
  endfunction

  task automatic random_phase(int count, logic [1:0] oss, int style);
    write_reg(bpc_pkg::REG_OSS, {62'b0, oss});
    case (style)
      0: begin
        write_reg(bpc_pkg::REG_CAL_A, typical_cal_a(1));
        write_reg(bpc_pkg::REG_CAL_B, typical_cal_b(1));
        write_reg(bpc_pkg::REG_CAL_C, typical_cal_c(1));
      end
      1: begin
        write_reg(bpc_pkg::REG_CAL_A, {$urandom, $urandom});
        write_reg(bpc_pkg::REG_CAL_B, {$urandom, $urandom});
        write_reg(bpc_pkg::REG_CAL_C, $urandom);
      end
      default: begin
        write_reg(bpc_pkg::REG_CAL_A, '1);
        write_reg(bpc_pkg::REG_CAL_B, '1);
        write_reg(bpc_pkg::REG_CAL_C, '1);
      end
    endcase
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: send_reading(bpc_pkg::CMD_TEMP,
                              {8'($urandom), 16'($urandom_range(20000, 36000))});
        3, 4, 5, 6: send_reading(bpc_pkg::CMD_PRESS,
                                 24'($urandom_range(24'h500000, 24'hA00000)));
        7: send_reading(bpc_pkg::CMD_TEMP, 24'($urandom));
        default: send_reading(bpc_pkg::CMD_PRESS, 24'($urandom));
      endcase
    end
    wait_idle();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset calibration: pressure uses the zero factor and hits a zero divisor,
    // temperature hits a zero divisor too.
    send_reading(bpc_pkg::CMD_PRESS, 24'h5D2300);
    send_reading(bpc_pkg::CMD_TEMP, 24'h006CFA);
    send_reading(bpc_pkg::CMD_TEMP, 24'hFFFFFF);
    send_reading(bpc_pkg::CMD_PRESS, 24'hFFFFFF);
    wait_idle();

    write_reg(bpc_pkg::REG_CAL_A, typical_cal_a(0));
    write_reg(bpc_pkg::REG_CAL_B, typical_cal_b(0));
    write_reg(bpc_pkg::REG_CAL_C, typical_cal_c(0));
    write_reg(bpc_pkg::REG_OSS, 64'd0);
    send_reading(bpc_pkg::CMD_TEMP, 24'h006CFA);
    send_reading(bpc_pkg::CMD_PRESS, 24'h5D2300);
    send_reading(bpc_pkg::CMD_PRESS, 24'h000000);
    send_reading(bpc_pkg::CMD_PRESS, 24'hFFFFFF);
    send_reading(bpc_pkg::CMD_TEMP, 24'h000000);
    send_reading(bpc_pkg::CMD_TEMP, 24'h00FFFF);
    send_reading(bpc_pkg::CMD_TEMP, 24'hFF6CFA);
    send_reading(bpc_pkg::CMD_PRESS, 24'h800000);
    wait_idle();

    // Zero temperature divisor with a nonzero mc: ac5 and md cleared.
    write_reg(bpc_pkg::REG_CAL_B, {16'd0, 16'd23153, 16'd6190, 16'd4});
    write_reg(bpc_pkg::REG_CAL_C, {-16'sd8711, 16'd0});
    send_reading(bpc_pkg::CMD_TEMP, 24'h006CFA);
    send_reading(bpc_pkg::CMD_PRESS, 24'h5D2300);
    wait_idle();

    hold_req = 1'b1;
    random_phase(240, 2'd3, 0);
    random_phase(240, 2'd0, 0);
    random_phase(200, 2'd1, 1);
    random_phase(240, 2'd2, 0);
    random_phase(80, 2'd3, 2);
    random_phase(240, 2'd0, 1);
    random_phase(240, 2'd1, 0);
    quiet = 1'b1;
    random_phase(350, 2'd2, 0);

    if (sb.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
